// ===== design/satt_pkg.sv =====
// Package for the sorted alarm timer table: action codes, default sizes and entry layout.
// Used by sorted_alarm_timer_table_unit; depends on nothing else.
package satt_pkg;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_DELETE  = 2'd1,
        ACT_SERVICE = 2'd2,
        ACT_ADJUST  = 2'd3
    } action_t;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_TICK_SHIFT = 5;

    localparam int EVENT_W    = 8;
    localparam int DELAY_W    = 32;
    localparam int TIME_W     = 64;
    localparam int COMPARE_W  = 32;
    localparam int ENTRY_W    = TIME_W + EVENT_W;
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 48;

endpackage

// ===== design/satt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module satt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sorted_alarm_timer_table_unit.sv =====
// Sorted alarm timer table: alarms held in deadline order in two ping-pong RAMs.
// Each item copies the list from one bank to the other, changing it on the way.
// Each listed alarm passes S_RD and S_PROC, with a second S_PROC pass when an add goes ahead of it;
// then S_TAIL and S_STATUS. Output stalls hold S_PROC on a fired alarm and hold S_STATUS.
// Throughput: one item at a time; the next item is taken once the status item is loaded.
// Reset (aresetn low, synchronous) empties the list; RAM contents are not cleared.
// Depends on satt_pkg and satt_ram.
module sorted_alarm_timer_table_unit
    import satt_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int TICK_SHIFT = DEF_TICK_SHIFT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action[1:0], event_id[9:2], delay[41:10], now[105:42], offset[169:106], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fired_event[7:0], alarm_enabled[8], alarm_compare[40:9], table_full[41], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_SLOTS);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_TAIL, S_STATUS} state_t;

    state_t               state_reg;
    logic                 bank_reg;
    action_t              act_reg;
    logic [EVENT_W-1:0]   ev_reg;
    logic [TIME_W-1:0]    t_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    off_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic [CNT_W-1:0]     wr_idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ins_reg;
    logic                 found_reg;
    logic [TIME_W-1:0]    old_head_reg;
    logic [TIME_W-1:0]    new_head_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    logic [ENTRY_W-1:0]   rd0_data;
    logic [ENTRY_W-1:0]   rd1_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic [EVENT_W-1:0]   e_ev;
    logic [TIME_W-1:0]    e_dl;
    logic                 wr_req;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 adv;
    logic                 set_ins;
    logic                 set_found;
    logic                 fire;
    logic                 out_free;
    logic                 head_eq;
    logic                 full_c;
    logic                 enabled_c;
    logic [TIME_W-1:0]    head_c;
    logic [TIME_W-1:0]    t_c;
    logic [CNT_W-1:0]     rd_idx_inc;

    satt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_ram0 (
        .aclk    (aclk),
        .wr_en   (wr_en && bank_reg),
        .wr_addr (wr_idx_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd0_data)
    );

    satt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_ram1 (
        .aclk    (aclk),
        .wr_en   (wr_en && !bank_reg),
        .wr_addr (wr_idx_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd1_data)
    );

    assign rd_data    = bank_reg ? rd1_data : rd0_data;
    assign e_ev       = rd_data[EVENT_W-1:0];
    assign e_dl       = rd_data[ENTRY_W-1:EVENT_W];
    assign out_free   = !m_valid_reg || m_tready;
    assign head_eq    = (rd_idx_reg == '0) || (e_dl == old_head_reg);
    assign rd_idx_inc = rd_idx_reg + 1'b1;
    assign wr_en      = wr_req && (wr_idx_reg < NUM_C);
    assign t_c        = (TIME_W'(s_tdata[41:10]) << TICK_SHIFT) + s_tdata[105:42];
    assign full_c     = (act_reg == ACT_ADD) && !found_reg && (count_reg == NUM_C);
    assign enabled_c  = full_c ? (count_reg != '0) : (wr_idx_reg != '0);
    assign head_c     = full_c ? old_head_reg : new_head_reg;

    always_comb begin
        wr_req    = 1'b0;
        wr_data   = rd_data;
        adv       = 1'b0;
        set_ins   = 1'b0;
        set_found = 1'b0;
        fire      = 1'b0;
        if (state_reg == S_PROC) begin
            case (act_reg)
                ACT_ADD: begin
                    if (e_ev == ev_reg) begin
                        set_found = 1'b1;
                        adv       = 1'b1;
                    end else if (!ins_reg && (e_dl >= t_reg)) begin
                        wr_req  = 1'b1;
                        wr_data = {t_reg, ev_reg};
                        set_ins = 1'b1;
                    end else begin
                        wr_req = 1'b1;
                        adv    = 1'b1;
                    end
                end
                ACT_DELETE: begin
                    wr_req = (e_ev != ev_reg);
                    adv    = 1'b1;
                end
                ACT_SERVICE: begin
                    if (head_eq || (e_dl <= now_reg)) begin
                        fire = out_free;
                        adv  = out_free;
                    end else begin
                        wr_req = 1'b1;
                        adv    = 1'b1;
                    end
                end
                ACT_ADJUST: begin
                    wr_req  = 1'b1;
                    wr_data = {e_dl + off_reg, e_ev};
                    adv     = 1'b1;
                end
                default: begin
                    adv = 1'b1;
                end
            endcase
        end else if (state_reg == S_TAIL) begin
            if ((act_reg == ACT_ADD) && !ins_reg) begin
                wr_req  = 1'b1;
                wr_data = {t_reg, ev_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !fire && !((state_reg == S_STATUS) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
                if (wr_idx_reg == '0) begin
                    new_head_reg <= wr_data[ENTRY_W-1:EVENT_W];
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg    <= action_t'(s_tdata[1:0]);
                        ev_reg     <= s_tdata[9:2];
                        t_reg      <= t_c;
                        now_reg    <= s_tdata[105:42];
                        off_reg    <= s_tdata[169:106];
                        rd_idx_reg <= '0;
                        wr_idx_reg <= '0;
                        ins_reg    <= 1'b0;
                        found_reg  <= 1'b0;
                        state_reg  <= (count_reg == '0) ? S_TAIL : S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_PROC;
                end
                S_PROC: begin
                    if (rd_idx_reg == '0) begin
                        old_head_reg <= e_dl;
                    end
                    if (set_ins) begin
                        ins_reg <= 1'b1;
                    end
                    if (set_found) begin
                        found_reg <= 1'b1;
                    end
                    if (fire) begin
                        m_valid_reg <= 1'b1;
                        m_tuser_reg <= 1'b0;
                        m_tlast_reg <= 1'b0;
                        m_tdata_reg <= M_TDATA_W'(e_ev);
                    end
                    if (adv) begin
                        rd_idx_reg <= rd_idx_inc;
                        state_reg  <= (rd_idx_inc == count_reg) ? S_TAIL : S_RD;
                    end
                end
                S_TAIL: begin
                    state_reg <= S_STATUS;
                end
                S_STATUS: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_tuser_reg <= 1'b1;
                        m_tlast_reg <= 1'b1;
                        m_tdata_reg <= M_TDATA_W'({full_c,
                            enabled_c ? head_c[COMPARE_W-1:0] : {COMPARE_W{1'b0}},
                            enabled_c, {EVENT_W{1'b0}}});
                        if (!full_c) begin
                            count_reg <= wr_idx_reg;
                            bank_reg  <= !bank_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
